### rtl/assert_macros.svh
// assertion macros for the unique key deque rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define UKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define UKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ukd_pkg.sv
// types and codes of the unique key deque
// no dependencies
`default_nettype none

package ukd_pkg;

  localparam int unsigned KEY_W = 32;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_REM_FIRST = 2'd1,
    OP_REM_LAST  = 2'd2,
    OP_LIST      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_APPENDED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_REMOVED   = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_LISTED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_LIST
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] value;
    logic                    last;
  } result_t;

  // handshake between the back end and the queues around it
  typedef struct packed {
    logic cmd_valid;
    logic cmd_pop;
    logic res_full;
    logic res_push;
  } back_ctl_t;

endpackage

`default_nettype wire

### rtl/ukd_fifo.sv
// small register fifo used for the command and result queues
// depends on nothing but its parameters
`default_nettype none

module ukd_fifo #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/ukd_back.sv
// back end of the unique key deque: circular key store and command sequencer
// depends on ukd_pkg
`default_nettype none

module ukd_back import ukd_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cmd_valid_i,
  input  wire item_t   cmd_i,
  output logic         cmd_pop_o,
  input  wire logic    res_full_i,
  output logic         res_push_o,
  output result_t      res_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  logic signed [KEY_W-1:0] store_q [CAPACITY];

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        front_q, front_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q;
  logic [CAPACITY-1:0]     match_q, match_d;
  logic                    go;
  logic                    load_key;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_slot;
  logic [CNT_W-1:0]        rd_pos;
  logic [IDX_W-1:0]        rd_slot;
  logic signed [KEY_W-1:0] rd_data;
  logic                    store_full;
  logic                    store_empty;
  logic                    list_last;

  // physical slot of a logical position, wrapping at the capacity
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(front) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign store_full  = (count_q == CNT_W'(CAPACITY));
  assign store_empty = (count_q == '0);
  assign go          = cmd_valid_i && !res_full_i;
  assign list_last   = (pos_q == count_q - 1'b1);

  // one shared read port: head on remove first, tail on remove last, cursor on list
  always_comb begin
    if (state_q == S_LIST) begin
      rd_pos = pos_q;
    end else if (cmd_i.op == OP_REM_FIRST) begin
      rd_pos = '0;
    end else begin
      rd_pos = count_q - 1'b1;
    end
  end
  assign rd_slot = slot_of(front_q, rd_pos);
  assign rd_data = store_q[rd_slot];
  assign wr_slot = slot_of(front_q, count_q);

  // per slot compare against the incoming key, only inside the occupied window
  for (genvar s = 0; s < CAPACITY; s++) begin : g_cmp
    logic [CNT_W:0] off;
    assign off = ((CNT_W+1)'(s) >= (CNT_W+1)'(front_q))
               ? (CNT_W+1)'(s) - (CNT_W+1)'(front_q)
               : (CNT_W+1)'(s) + (CNT_W+1)'(CAPACITY) - (CNT_W+1)'(front_q);
    assign match_d[s] = (off < (CNT_W+1)'(count_q)) && (store_q[s] == cmd_i.key);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go && cmd_i.op == OP_APPEND) begin
          state_d = S_APPEND;
        end else if (go && cmd_i.op == OP_LIST && !store_empty) begin
          state_d = S_LIST;
        end
      end
      S_APPEND: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (!res_full_i && list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{status: STAT_EMPTY, value: '0, last: 1'b1};
    front_d    = front_q;
    count_d    = count_q;
    pos_d      = pos_q;
    load_key   = 1'b0;
    wr_en      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op) inside
            OP_APPEND: begin
              load_key = 1'b1;
            end
            OP_REM_FIRST, OP_REM_LAST: begin
              res_push_o = 1'b1;
              if (!store_empty) begin
                res_o.status = STAT_REMOVED;
                res_o.value  = rd_data;
                count_d      = count_q - 1'b1;
                if (count_q == CNT_W'(1)) begin
                  front_d = '0;
                end else if (cmd_i.op == OP_REM_FIRST) begin
                  front_d = slot_of(front_q, CNT_W'(1));
                end
              end
            end
            default: begin
              if (store_empty) begin
                res_push_o = 1'b1;
              end else begin
                pos_d = '0;
              end
            end
          endcase
        end
      end
      S_APPEND: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (|match_q) begin
            res_o.status = STAT_DUPLICATE;
          end else if (store_full) begin
            res_o.status = STAT_FULL;
          end else begin
            res_o.status = STAT_APPENDED;
            wr_en        = 1'b1;
            count_d      = count_q + 1'b1;
          end
        end
      end
      S_LIST: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.status = STAT_LISTED;
          res_o.value  = rd_data;
          res_o.last   = list_last;
          pos_d        = pos_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_key) begin
      key_q   <= cmd_i.key;
      match_q <= match_d;
    end
    if (wr_en) begin
      store_q[wr_slot] <= key_q;
    end
  end

endmodule

`default_nettype wire

### rtl/unique_key_deque_unit.sv
// unique key deque: append without duplicates, remove at either end, list
// flow: a transaction reaches the back end through the command queue; a removal result is
// decided as its command is taken, an append result after a registered key compare, then
// decision, list entries one per cycle while results have room (one for an empty store)
// throughput: one removal per cycle while results have room; an append delays the next
// command until decided; reset (rst_ni low, asynchronous) empties both queues and the store
`default_nettype none

module unique_key_deque_unit import ukd_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item_i,
  input  wire logic  pop,
  output logic       empty,
  output result_t    result_o
);

  `include "assert_macros.svh"

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(result_t);

  back_ctl_t         ctl;
  logic              cmd_empty;
  logic [ITEM_W-1:0] cmd_bits;
  item_t             cmd;
  result_t           res;
  logic [RES_W-1:0]  res_bits;

  // front: queue of accepted transactions ahead of the sequencer
  ukd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (ITEM_W'(item_i)),
    .rd_en_i   (ctl.cmd_pop),
    .rd_data_o (cmd_bits),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  assign cmd           = item_t'(cmd_bits);
  assign ctl.cmd_valid = !cmd_empty;

  ukd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (ctl.cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (ctl.cmd_pop),
    .res_full_i  (ctl.res_full),
    .res_push_o  (ctl.res_push),
    .res_o       (res)
  );

  // results wait here so the back end keeps going while the consumer stalls, until this queue fills
  ukd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ctl.res_push),
    .wr_data_i (RES_W'(res)),
    .rd_en_i   (pop),
    .rd_data_o (res_bits),
    .full_o    (ctl.res_full),
    .empty_o   (empty)
  );

  assign result_o = result_t'(res_bits);

  `UKD_ASSERT(a_res_no_overflow, !(ctl.res_push && ctl.res_full), "result queue overflow")
  `UKD_ASSERT(a_cmd_no_underflow, !(ctl.cmd_pop && !ctl.cmd_valid), "command queue underflow")
  `UKD_ASSERT_NEXT(a_push_lands, push && !full && !ctl.cmd_pop, ctl.cmd_valid, "transaction lost")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for unique_key_deque_unit
// depends on ukd_pkg for the item and result types and the op and status codes
// drives push/pop queues with random gaps, predicts every result in a scoreboard class

module tb;
  import ukd_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  item_t   item_i;
  logic    pop;
  logic    empty;
  result_t result_o;

  bit rx_steady;
  int idle_cycles;

  unique_key_deque_unit #(.CAPACITY(DEPTH)) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .pop      (pop),
    .empty    (empty),
    .result_o (result_o)
  );

  // mirror of the deque contents and the results each transaction must produce
  class deque_scoreboard;
    result_t            expected_q[$];
    logic signed [31:0] keys[DEPTH];
    logic [IDX_W-1:0]   head = '0;
    logic [IDX_W:0]     count = '0;
    int                 errors = 0;

    function int slot_at(int pos);
      return (int'(head) + pos) % DEPTH;
    endfunction

    function void add_result(status_e st, logic signed [31:0] val, logic lst);
      result_t r;
      r.status = st;
      r.value  = val;
      r.last   = lst;
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(item_t it);
      bit                 dup;
      logic signed [31:0] v;
      dup = 1'b0;
      case (it.op)
        OP_APPEND: begin
          for (int i = 0; i < int'(count); i++)
            if (keys[slot_at(i)] == it.key) dup = 1'b1;
          // duplicate wins over full
          if (dup) begin
            add_result(STAT_DUPLICATE, '0, 1'b1);
          end else if (count == DEPTH) begin
            add_result(STAT_FULL, '0, 1'b1);
          end else begin
            keys[slot_at(int'(count))] = it.key;
            count++;
            add_result(STAT_APPENDED, '0, 1'b1);
          end
        end
        OP_REM_FIRST, OP_REM_LAST: begin
          if (count == 0) begin
            add_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            if (it.op == OP_REM_FIRST) begin
              v = keys[slot_at(0)];
              head = IDX_W'(slot_at(1));
            end else begin
              v = keys[slot_at(int'(count) - 1)];
            end
            count--;
            if (count == 0) head = '0;
            add_result(STAT_REMOVED, v, 1'b1);
          end
        end
        default: begin
          if (count == 0) begin
            add_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < int'(count); i++)
              add_result(STAT_LISTED, keys[slot_at(i)], (i + 1 == int'(count)));
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0d last %0b",
                         got.status, got.value, got.last));
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.value !== want.value)
          report($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  deque_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t make_item(op_e op, logic signed [31:0] key);
    item_t it;
    it.op  = op;
    it.key = key;
    return it;
  endfunction

  // small key pool so duplicates are common, full-range keys for bit coverage
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(3) == 0) return $urandom;
    return int'($urandom_range(0, 23)) - 12;
  endfunction

  task automatic send_item(input item_t it, input int gap);
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every outstanding result has been popped
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int append_pct, input bit tx_steady);
    item_t it;
    int    r;
    int    sub;
    for (int k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      sub = $urandom_range(9);
      if (r < append_pct) it.op = OP_APPEND;
      else if (sub < 4)   it.op = OP_REM_FIRST;
      else if (sub < 8)   it.op = OP_REM_LAST;
      else                it.op = OP_LIST;
      it.key = pick_key();
      send_item(it, tx_steady ? 0 : pick_gap());
    end
  endtask

  // result side: pop with random stalls, check every transaction
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(result_o);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop && !empty) stall_left = rx_steady ? 0 : pick_gap();
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("unique_key_deque_unit test failed");
    $finish;
  end

  initial begin
    sb        = new;
    rx_steady = 1'b0;
    rst_ni    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    item_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, extreme keys, duplicate, wrap, full
    send_item(make_item(OP_REM_FIRST, 32'h5A5A_5A5A), pick_gap());
    send_item(make_item(OP_REM_LAST, 32'hA5A5_A5A5), pick_gap());
    send_item(make_item(OP_LIST, 32'hFFFF_FFFF), pick_gap());
    send_item(make_item(OP_APPEND, 32'sh8000_0000), pick_gap());
    send_item(make_item(OP_APPEND, 32'sh7FFF_FFFF), pick_gap());
    send_item(make_item(OP_APPEND, 32'sh0000_0000), pick_gap());
    send_item(make_item(OP_APPEND, -32'sd1), pick_gap());
    send_item(make_item(OP_APPEND, -32'sd1), pick_gap());
    send_item(make_item(OP_REM_FIRST, '0), pick_gap());
    // head is now off slot zero, so filling up wraps the tail
    for (int k = 0; k < 13; k++)
      send_item(make_item(OP_APPEND, 32'sd100 + k), 0);
    send_item(make_item(OP_APPEND, 32'sd555), pick_gap());
    send_item(make_item(OP_APPEND, 32'sh7FFF_FFFF), pick_gap());
    send_item(make_item(OP_LIST, '0), pick_gap());
    send_item(make_item(OP_REM_LAST, '0), pick_gap());
    drain();

    // random: fill up, balanced bursts, drain down, balanced
    run_phase(60, 75, 1'b0);
    drain();
    rx_steady = 1'b1;
    run_phase(70, 45, 1'b1);
    drain();
    rx_steady = 1'b0;
    run_phase(55, 20, 1'b0);
    drain();
    run_phase(60, 50, 1'b0);
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("unique_key_deque_unit test passed");
    else
      $display("unique_key_deque_unit test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ukd_pkg.sv
rtl/ukd_fifo.sv
rtl/ukd_back.sv
rtl/unique_key_deque_unit.sv
tb/sv/tb.sv
